// File: hw/rtl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

  localparam int unsigned NTerms = 7;

  // Stage counts: fold, square, three per series term, sign; then the product tree.
  localparam int unsigned SincosLat = 3 * NTerms + 3;
  localparam int unsigned QuatLat   = 5;
  localparam int unsigned PipeLat   = SincosLat + QuatLat;

  localparam logic signed [31:0] HalfPi = 32'sd421657428;
  localparam logic signed [31:0] PiQ28  = 32'sd843314857;
  localparam logic signed [30:0] OneQ28 = 31'sd268435456;
  localparam logic [17:0]        QuatMax = 18'd16384;

  // Term divisors halved (the factor two is taken by the shift), with floor(2^32 / d).
  localparam logic [6:0] SinDiv [NTerms] = '{7'd3, 7'd10, 7'd21, 7'd36, 7'd55, 7'd78, 7'd105};
  localparam logic [6:0] CosDiv [NTerms] = '{7'd1, 7'd6, 7'd15, 7'd28, 7'd45, 7'd66, 7'd91};
  localparam logic [32:0] SinRecip [NTerms] = '{
    33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
    33'd78090314, 33'd55063683, 33'd40904450};
  localparam logic [32:0] CosRecip [NTerms] = '{
    33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
    33'd95443717, 33'd65075262, 33'd47197442};

  typedef logic signed [29:0] trig_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } pose_t;

  // Q.28 product back to Q.28, truncating toward zero.
  function automatic logic signed [31:0] trunc_q28(input logic signed [59:0] v);
    logic signed [59:0] b;
    b = v + (v[59] ? 60'sd268435455 : 60'sd0);
    return b[59:28];
  endfunction

  // Round to Q1.14, ties away from zero, saturate to +/- one.
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic [31:0] m;
    logic [17:0] r;
    logic [15:0] u;
    m = v[31] ? 32'(-v) : 32'(v);
    r = 18'((m + 32'd8192) >> 14);
    if (r > QuatMax) r = QuatMax;
    u = r[15:0];
    return v[31] ? $signed(-u) : $signed(u);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/euler_to_quaternion_pose_top.sv
// Channel | Direction | Handshake              | Word
// in      | sink      | in_valid_i / in_stall_o  | pos_x/y/z, roll/pitch/yaw angle
// out     | source    | out_valid_o / out_stall_i| out_x/y/z, quat_w/x/y/z
//
// One word accepted per cycle while in_stall_o is low; each result passes through
// the three half-angle sine/cosine series, then the product tree, to the output register.
// Reset clears the valid bits of the pipeline, output register and skid stage.
// A result arriving while the output word is stalled parks in the skid stage;
// the pipeline then holds until the skid stage drains, and in_stall_o follows that register.
`default_nettype none
module euler_to_quaternion_pose_top import e2q_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] roll_angle_i,
  input  wire logic signed [15:0] pitch_angle_i,
  input  wire logic signed [15:0] yaw_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic signed [15:0]      quat_x_o,
  output logic signed [15:0]      quat_y_o,
  output logic signed [15:0]      quat_z_o
);

  logic               en;
  logic [PipeLat-1:0] vld_q;
  logic signed [31:0] px_q [PipeLat];
  logic signed [31:0] py_q [PipeLat];
  logic signed [31:0] pz_q [PipeLat];
  trig_t              sr, cr, sp, cp, sy, cy;
  logic signed [15:0] qw, qx, qy, qz;
  pose_t              res;
  pose_t              out_q, out_d, skid_q, skid_d;
  logic               out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic               push, pop;

  assign en         = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= pos_x_i;
      py_q[0] <= pos_y_i;
      pz_q[0] <= pos_z_i;
      for (int i = 1; i < PipeLat; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
        pz_q[i] <= pz_q[i-1];
      end
    end
  end

  e2q_sincos u_roll  (.clk_i, .en_i(en), .angle_i(roll_angle_i),  .sin_o(sr), .cos_o(cr));
  e2q_sincos u_pitch (.clk_i, .en_i(en), .angle_i(pitch_angle_i), .sin_o(sp), .cos_o(cp));
  e2q_sincos u_yaw   (.clk_i, .en_i(en), .angle_i(yaw_angle_i),   .sin_o(sy), .cos_o(cy));

  e2q_quat u_quat (
    .clk_i, .en_i(en),
    .sr_i(sr), .cr_i(cr), .sp_i(sp), .cp_i(cp), .sy_i(sy), .cy_i(cy),
    .qw_o(qw), .qx_o(qx), .qy_o(qy), .qz_o(qz)
  );

  assign res  = '{x: px_q[PipeLat-1], y: py_q[PipeLat-1], z: pz_q[PipeLat-1],
                  qw: qw, qx: qx, qy: qy, qz: qz};
  assign push = en & vld_q[PipeLat-1];
  assign pop  = out_vld_q & ~out_stall_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end else begin
        out_d     = res;
        out_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_z_o     = out_q.z;
  assign quat_w_o    = out_q.qw;
  assign quat_x_o    = out_q.qx;
  assign quat_y_o    = out_q.qy;
  assign quat_z_o    = out_q.qz;

endmodule
`default_nettype wire

// File: hw/rtl/e2q_sincos.sv
`default_nettype none
module e2q_sincos import e2q_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] angle_i,
  output trig_t                   sin_o,
  output trig_t                   cos_o
);

  logic signed [31:0] h_ext, h_fold;
  logic               flip;
  trig_t              h_q;
  logic               flip_q;

  assign h_ext = {{2{angle_i[15]}}, angle_i, 14'd0};

  always_comb begin
    h_fold = h_ext;
    flip   = 1'b0;
    if (h_ext > HalfPi) begin
      h_fold = h_ext - PiQ28;
      flip   = 1'b1;
    end else if (h_ext < -HalfPi) begin
      h_fold = h_ext + PiQ28;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= h_fold[29:0];
      flip_q <= flip;
    end
  end

  // Series state; index k feeds term k, index NTerms is the finished sum.
  logic [28:0]        mag_s [NTerms+1];
  logic [28:0]        mag_c [NTerms+1];
  logic signed [30:0] acc_s [NTerms+1];
  logic signed [30:0] acc_c [NTerms+1];
  logic [29:0]        x2    [NTerms+1];
  logic [1:0]         sg    [NTerms+1];   // {cos negate, sin negate}

  logic signed [59:0] hh;
  logic [28:0]        hmag;
  assign hh   = 60'(h_q) * 60'(h_q);
  assign hmag = h_q[29] ? 29'(-h_q) : 29'(h_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_s[0] <= hmag;
      mag_c[0] <= 29'(OneQ28);
      acc_s[0] <= $signed({2'b00, hmag});
      acc_c[0] <= OneQ28;
      x2[0]    <= hh[57:28];
      sg[0]    <= {flip_q, flip_q ^ h_q[29]};
    end
  end

  for (genvar k = 0; k < NTerms; k++) begin : g_term
    logic [58:0]        pa_s_q, pa_c_q;
    logic [29:0]        n_s_q, n_c_q, q0_s_q, q0_c_q;
    logic signed [30:0] acc_s_a_q, acc_c_a_q, acc_s_b_q, acc_c_b_q;
    logic [29:0]        x2_a_q, x2_b_q;
    logic [1:0]         sg_a_q, sg_b_q;
    logic [29:0]        n_s, n_c;
    logic [62:0]        pr_s, pr_c;
    logic [36:0]        qm_s, qm_c, r_s, r_c;
    logic [29:0]        q_s, q_c;

    // multiply by x^2
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_s_q    <= 59'(mag_s[k]) * 59'(x2[k]);
        pa_c_q    <= 59'(mag_c[k]) * 59'(x2[k]);
        acc_s_a_q <= acc_s[k];
        acc_c_a_q <= acc_c[k];
        x2_a_q    <= x2[k];
        sg_a_q    <= sg[k];
      end
    end

    // quotient estimate by reciprocal, never above the true quotient
    assign n_s  = pa_s_q[58:29];
    assign n_c  = pa_c_q[58:29];
    assign pr_s = 63'(n_s) * 63'(SinRecip[k]);
    assign pr_c = 63'(n_c) * 63'(CosRecip[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_s_q     <= n_s;
        n_c_q     <= n_c;
        q0_s_q    <= pr_s[61:32];
        q0_c_q    <= pr_c[61:32];
        acc_s_b_q <= acc_s_a_q;
        acc_c_b_q <= acc_c_a_q;
        x2_b_q    <= x2_a_q;
        sg_b_q    <= sg_a_q;
      end
    end

    // one-step correction, then fold the term into the alternating sum
    assign qm_s = 37'(q0_s_q) * 37'(SinDiv[k]);
    assign qm_c = 37'(q0_c_q) * 37'(CosDiv[k]);
    assign r_s  = 37'(n_s_q) - qm_s;
    assign r_c  = 37'(n_c_q) - qm_c;
    assign q_s  = q0_s_q + 30'(r_s >= 37'(SinDiv[k]));
    assign q_c  = q0_c_q + 30'(r_c >= 37'(CosDiv[k]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_s[k+1] <= q_s[28:0];
        mag_c[k+1] <= q_c[28:0];
        if (k % 2 == 0) begin
          acc_s[k+1] <= acc_s_b_q - $signed({1'b0, q_s});
          acc_c[k+1] <= acc_c_b_q - $signed({1'b0, q_c});
        end else begin
          acc_s[k+1] <= acc_s_b_q + $signed({1'b0, q_s});
          acc_c[k+1] <= acc_c_b_q + $signed({1'b0, q_c});
        end
        x2[k+1] <= x2_b_q;
        sg[k+1] <= sg_b_q;
      end
    end
  end

  logic signed [30:0] neg_s, neg_c;
  trig_t              sin_q, cos_q;
  assign neg_s = -acc_s[NTerms];
  assign neg_c = -acc_c[NTerms];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sg[NTerms][0] ? neg_s[29:0] : acc_s[NTerms][29:0];
      cos_q <= sg[NTerms][1] ? neg_c[29:0] : acc_c[NTerms][29:0];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

// File: hw/rtl/e2q_quat.sv
`default_nettype none
module e2q_quat import e2q_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire trig_t       sr_i,
  input  wire trig_t       cr_i,
  input  wire trig_t       sp_i,
  input  wire trig_t       cp_i,
  input  wire trig_t       sy_i,
  input  wire trig_t       cy_i,
  output logic signed [15:0] qw_o,
  output logic signed [15:0] qx_o,
  output logic signed [15:0] qy_o,
  output logic signed [15:0] qz_o
);

  // roll/pitch pair products: cc, ss, sc, cs
  logic signed [59:0] ab_q [4];
  trig_t              sy1_q, cy1_q, sy2_q, cy2_q;
  logic signed [31:0] p_q  [4];
  logic signed [59:0] pr_q [8];
  logic signed [31:0] v_q  [4];
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q[0] <= 60'(cr_i) * 60'(cp_i);
      ab_q[1] <= 60'(sr_i) * 60'(sp_i);
      ab_q[2] <= 60'(sr_i) * 60'(cp_i);
      ab_q[3] <= 60'(cr_i) * 60'(sp_i);
      sy1_q   <= sy_i;
      cy1_q   <= cy_i;
      for (int i = 0; i < 4; i++) p_q[i] <= trunc_q28(ab_q[i]);
      sy2_q   <= sy1_q;
      cy2_q   <= cy1_q;
      pr_q[0] <= 60'(p_q[0]) * 60'(cy2_q);  // w
      pr_q[1] <= 60'(p_q[1]) * 60'(sy2_q);
      pr_q[2] <= 60'(p_q[2]) * 60'(cy2_q);  // x
      pr_q[3] <= 60'(p_q[3]) * 60'(sy2_q);
      pr_q[4] <= 60'(p_q[3]) * 60'(cy2_q);  // y
      pr_q[5] <= 60'(p_q[2]) * 60'(sy2_q);
      pr_q[6] <= 60'(p_q[0]) * 60'(sy2_q);  // z
      pr_q[7] <= 60'(p_q[1]) * 60'(cy2_q);
      v_q[0]  <= trunc_q28(pr_q[0]) + trunc_q28(pr_q[1]);
      v_q[1]  <= trunc_q28(pr_q[2]) - trunc_q28(pr_q[3]);
      v_q[2]  <= trunc_q28(pr_q[4]) + trunc_q28(pr_q[5]);
      v_q[3]  <= trunc_q28(pr_q[6]) - trunc_q28(pr_q[7]);
      qw_q    <= to_q14(v_q[0]);
      qx_q    <= to_q14(v_q[1]);
      qy_q    <= to_q14(v_q[2]);
      qz_q    <= to_q14(v_q[3]);
    end
  end

  assign qw_o = qw_q;
  assign qx_o = qx_q;
  assign qy_o = qy_q;
  assign qz_o = qz_q;

endmodule
`default_nettype wire

// File: hw/rtl/e2q_checker.sv
`default_nettype none
module e2q_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] quat_w_o,
  input wire logic signed [15:0] quat_x_o,
  input wire logic signed [15:0] quat_y_o,
  input wire logic signed [15:0] quat_z_o
);

  logic signed [33:0] norm;
  assign norm = 34'(quat_w_o) * 34'(quat_w_o) + 34'(quat_x_o) * 34'(quat_x_o)
              + 34'(quat_y_o) * 34'(quat_y_o) + 34'(quat_z_o) * 34'(quat_z_o);

  // held word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o >= -16'sd16384 && quat_w_o <= 16'sd16384 &&
                    quat_x_o >= -16'sd16384 && quat_x_o <= 16'sd16384 &&
                    quat_y_o >= -16'sd16384 && quat_y_o <= 16'sd16384 &&
                    quat_z_o >= -16'sd16384 && quat_z_o <= 16'sd16384)
    else $error("quaternion component out of range");

  // unit length within rounding slack
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> norm > 34'sd267911168 && norm < 34'sd268959744)
    else $error("quaternion not unit length");

  // input backpressure only comes from a stalled, occupied output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind euler_to_quaternion_pose_top e2q_checker u_e2q_checker (.*);
`default_nettype wire
